/* sv/sgb_pkg.sv */
// shared types, constants and the gray conversion for the sobel edge binarizer
// no dependencies; imported by every module of the block

package sgb_pkg;

    // default geometry limits
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 4096;

    // register reset values
    localparam logic [11:0] WIDTH_RESET     = 12'd640;
    localparam logic [12:0] HEIGHT_RESET    = 13'd480;
    localparam logic [10:0] THRESHOLD_RESET = 11'd254;

    // configuration register indexes
    typedef enum logic [1:0]
    {
        REG_IMAGE_WIDTH    = 2'd0,
        REG_IMAGE_HEIGHT   = 2'd1,
        REG_EDGE_THRESHOLD = 2'd2,
        REG_UNUSED         = 2'd3
    } cfg_reg_t;

    // output pixel codes
    localparam logic [7:0] EDGE_MARK = 8'd0;
    localparam logic [7:0] FLAT_MARK = 8'd255;

    // luma weights scaled by 256
    localparam logic [7:0] GRAY_R = 8'd54;
    localparam logic [7:0] GRAY_G = 8'd184;
    localparam logic [7:0] GRAY_B = 8'd18;

    // per-pixel position flags from the position unit
    typedef struct packed
    {
        logic has_result;  // center pixel above-left exists
        logic first_col;   // column 1, left border mirrored
        logic second_row;  // row 1, top border mirrored
        logic last_pixel;  // bottom-right pixel of the frame
    } pos_flags_t;

    function automatic logic [7:0] gray_of(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
        logic [15:0] acc;
        acc = 16'(GRAY_R * r) + 16'(GRAY_G * g) + 16'(GRAY_B * b);
        return acc[15:8];
    endfunction

endpackage

/* sv/gray_sobel_edge_binarizer.sv */
// top level of the sobel edge binarizer: stream ports, config registers, pipeline
// depends on sgb_pkg, sgb_pos_counter, sgb_line_store, sgb_sobel_core
//
// usage
//   input stream s_*: one rgb pixel per transaction in raster order; s_tuser
//   marks the first pixel of a frame and restarts the position counters
//   output stream m_*: one binarized pixel per transaction for every center
//   pixel outside the last row and column, which give no result (the first row
//   and column use mirrored borders); m_tlast flags the result for center (width-2, height-2)
//   config channel cfg_*: register writes, always ready; write only while idle
// timing
//   stage 0 (accept): position counters, gray conversion, line store read
//   stage 1: window assembly, sobel, threshold; result goes to the output register
//   a result passes the stage 1 registers and then the output register before m_tvalid
//   throughput is one pixel per clock unless backpressure stalls, set by one read and one write per line store
// reset
//   counters and window clear, registers return to 640 x 480, threshold 254;
//   line stores hold no reset value and are filled by the first two rows
// backpressure
//   while m_tready is low one result waits in the output register; stage 1
//   then holds a pixel that has a result, and s_tready drops until space frees

module gray_sobel_edge_binarizer
    import sgb_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input pixels
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // red[7:0], green[15:8], blue[23:16]
    input  logic [0:0]  s_tuser,    // start_of_frame[0]
    // binarized results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // edge_value[7:0], out_column[18:8], out_row[30:19], pad
    output logic        m_tlast,    // end_of_frame
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int CWX = (CW > 11) ? CW : 11;
    localparam int RWX = (RW > 12) ? RW : 12;

    // configuration registers
    logic [11:0] width_reg;
    logic [12:0] height_reg;
    logic [10:0] threshold_reg;

    // stage 0 signals
    logic          in_accept;
    logic [CW-1:0] pos_col;
    logic [RW-1:0] pos_row;
    pos_flags_t    pos_flags;
    logic [7:0]    gray_in;

    // stage 1 registers
    logic          s1_valid_reg, s1_valid_next;
    logic [CW-1:0] s1_addr_reg;
    logic [7:0]    s1_gray_reg;
    logic [10:0]   s1_ocol_reg;
    logic [11:0]   s1_orow_reg;
    pos_flags_t    s1_flags_reg;
    logic          s1_fwd_reg;
    logic [7:0]    s1_fwd_top_reg;
    logic [7:0]    s1_fwd_mid_reg;
    logic          s1_retire;
    logic [7:0]    up_q, md_q;
    logic [7:0]    top_raw, top_eff, mid_eff;
    logic [7:0]    win_reg [6];
    logic [7:0]    s1_edge;

    // output register
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_edge_reg;
    logic [10:0]   out_col_reg;
    logic [11:0]   out_row_reg;
    logic          out_last_reg;
    logic          out_free;

    // config writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:    width_reg     <= cfg_data[11:0];
                REG_IMAGE_HEIGHT:   height_reg    <= cfg_data;
                REG_EDGE_THRESHOLD: threshold_reg <= cfg_data[10:0];
                REG_UNUSED:         ;
                default:            ;
            endcase
        end
    end

    // handshake: stage 1 retires when it has no result or the output slot frees
    assign out_free  = !out_valid_reg || m_tready;
    assign s1_retire = s1_valid_reg && (!s1_flags_reg.has_result || out_free);
    assign s_tready  = !s1_valid_reg || s1_retire;
    assign in_accept = s_tvalid && s_tready;

    // stage 0
    sgb_pos_counter #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW),
        .RW         (RW)
    ) u_pos (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (in_accept),
        .sof        (s_tuser[0]),
        .width_cfg  (width_reg),
        .height_cfg (height_reg),
        .col        (pos_col),
        .row        (pos_row),
        .flags      (pos_flags)
    );

    assign gray_in = gray_of(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]);

    // line stores: read on accept, written when the pixel retires from stage 1
    sgb_line_store #(
        .DEPTH   (MAX_WIDTH),
        .AW      (CW)
    ) u_upper (
        .clk     (clk),
        .wr_en   (s1_retire),
        .wr_addr (s1_addr_reg),
        .wr_data (mid_eff),
        .rd_en   (in_accept),
        .rd_addr (pos_col),
        .rd_data (up_q)
    );

    sgb_line_store #(
        .DEPTH   (MAX_WIDTH),
        .AW      (CW)
    ) u_middle (
        .clk     (clk),
        .wr_en   (s1_retire),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_gray_reg),
        .rd_en   (in_accept),
        .rd_addr (pos_col),
        .rd_data (md_q)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (s1_retire)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // stage 1 payload; a pixel that reuses the column being written takes bypass data
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_addr_reg    <= pos_col;
            s1_gray_reg    <= gray_in;
            s1_ocol_reg    <= 11'(CWX'(pos_col) - CWX'(1));
            s1_orow_reg    <= 12'(RWX'(pos_row) - RWX'(1));
            s1_flags_reg   <= pos_flags;
            s1_fwd_reg     <= s1_valid_reg && (s1_addr_reg == pos_col);
            s1_fwd_top_reg <= mid_eff;
            s1_fwd_mid_reg <= s1_gray_reg;
        end
    end

    // stage 1: column above and two above, top border mirrored on row 1
    assign mid_eff = s1_fwd_reg ? s1_fwd_mid_reg : md_q;
    assign top_raw = s1_fwd_reg ? s1_fwd_top_reg : up_q;
    assign top_eff = s1_flags_reg.second_row ? s1_gray_reg : top_raw;

    sgb_sobel_core u_sobel (
        .win        (win_reg),
        .top        (top_eff),
        .mid        (mid_eff),
        .bot        (s1_gray_reg),
        .first_col  (s1_flags_reg.first_col),
        .threshold  (threshold_reg),
        .edge_value (s1_edge)
    );

    // window columns shift as each pixel retires
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_retire)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top_eff;
            win_reg[4] <= mid_eff;
            win_reg[5] <= s1_gray_reg;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_retire && s1_flags_reg.has_result)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_retire && s1_flags_reg.has_result)
        begin
            out_edge_reg <= s1_edge;
            out_col_reg  <= s1_ocol_reg;
            out_row_reg  <= s1_orow_reg;
            out_last_reg <= s1_flags_reg.last_pixel;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_row_reg, out_col_reg, out_edge_reg};
    assign m_tlast  = out_last_reg;

endmodule

/* sv/sgb_line_store.sv */
// one line store: single write port, single registered read port
// depends on sgb_pkg

module sgb_line_store
    import sgb_pkg::*;
#(
    parameter int DEPTH = MAX_WIDTH_DEF,
    parameter int AW    = $clog2(MAX_WIDTH_DEF)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/sgb_pos_counter.sv */
// raster position counters with clamped geometry and frame flags
// depends on sgb_pkg

module sgb_pos_counter
    import sgb_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int CW         = $clog2(MAX_WIDTH_DEF),
    parameter int RW         = $clog2(MAX_HEIGHT_DEF)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic          sof,
    input  logic [11:0]   width_cfg,
    input  logic [12:0]   height_cfg,
    output logic [CW-1:0] col,
    output logic [RW-1:0] row,
    output pos_flags_t    flags
);

    localparam int WE = (CW + 1 > 12) ? CW + 1 : 12;
    localparam int HE = (RW + 1 > 13) ? RW + 1 : 13;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [WE-1:0] w_ext;
    logic [HE-1:0] h_ext;
    logic [CW:0]   w_eff, c_pre, c_cur, c_inc;
    logic [RW:0]   h_eff, r_pre, r_adv, r_cur, r_inc;

    // geometry clamped to the supported range
    always_comb
    begin
        w_ext = WE'(width_cfg);
        h_ext = HE'(height_cfg);
        priority if (w_ext < WE'(3))
            w_eff = (CW + 1)'(3);
        else if (w_ext > WE'(MAX_WIDTH))
            w_eff = (CW + 1)'(MAX_WIDTH);
        else
            w_eff = w_ext[CW:0];
        priority if (h_ext < HE'(3))
            h_eff = (RW + 1)'(3);
        else if (h_ext > HE'(MAX_HEIGHT))
            h_eff = (RW + 1)'(MAX_HEIGHT);
        else
            h_eff = h_ext[RW:0];
    end

    // position of the arriving pixel
    always_comb
    begin
        c_pre = sof ? '0 : {1'b0, col_reg};
        r_pre = sof ? '0 : {1'b0, row_reg};
        if (c_pre >= w_eff)
        begin
            c_cur = '0;
            r_adv = r_pre + (RW + 1)'(1);
        end
        else
        begin
            c_cur = c_pre;
            r_adv = r_pre;
        end
        r_cur = (r_adv >= h_eff) ? '0 : r_adv;

        c_inc = c_cur + (CW + 1)'(1);
        r_inc = r_cur + (RW + 1)'(1);
        if (c_inc >= w_eff)
        begin
            col_next = '0;
            row_next = (r_inc >= h_eff) ? '0 : r_inc[RW-1:0];
        end
        else
        begin
            col_next = c_inc[CW-1:0];
            row_next = r_cur[RW-1:0];
        end
    end

    assign col              = c_cur[CW-1:0];
    assign row              = r_cur[RW-1:0];
    assign flags.has_result = (c_cur != '0) && (r_cur != '0);
    assign flags.first_col  = (c_cur == (CW + 1)'(1));
    assign flags.second_row = (r_cur == (RW + 1)'(1));
    assign flags.last_pixel = (c_cur == w_eff - (CW + 1)'(1))
                           && (r_cur == h_eff - (RW + 1)'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (step)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

/* sv/sgb_sobel_core.sv */
// 3x3 sobel kernel, gradient magnitude and threshold compare
// depends on sgb_pkg

module sgb_sobel_core
    import sgb_pkg::*;
(
    input  logic [7:0]  win [6],     // older column 0..2, newer column 3..5
    input  logic [7:0]  top,
    input  logic [7:0]  mid,
    input  logic [7:0]  bot,
    input  logic        first_col,
    input  logic [10:0] threshold,
    output logic [7:0]  edge_value
);

    logic signed [11:0] l0, l1, l2, m0, m2, r0, r1, r2;
    logic signed [11:0] gx, gy;
    logic        [11:0] ax, ay, mag;

    always_comb
    begin
        // left border mirrors column 1
        l0 = first_col ? $signed({4'b0, top}) : $signed({4'b0, win[0]});
        l1 = first_col ? $signed({4'b0, mid}) : $signed({4'b0, win[1]});
        l2 = first_col ? $signed({4'b0, bot}) : $signed({4'b0, win[2]});
        m0 = $signed({4'b0, win[3]});
        m2 = $signed({4'b0, win[5]});
        r0 = $signed({4'b0, top});
        r1 = $signed({4'b0, mid});
        r2 = $signed({4'b0, bot});

        gx = (r0 + (r1 <<< 1) + r2) - (l0 + (l1 <<< 1) + l2);
        gy = (l2 + (m2 <<< 1) + r2) - (l0 + (m0 <<< 1) + r0);
        ax = gx[11] ? 12'(-gx) : 12'(gx);
        ay = gy[11] ? 12'(-gy) : 12'(gy);
        mag = ax + ay;
        edge_value = (mag >= {1'b0, threshold}) ? EDGE_MARK : FLAT_MARK;
    end

endmodule

/* sv/sgb_checker.sv */
// port-level checks for the sobel edge binarizer, bound to the top level
// depends on sgb_pkg and gray_sobel_edge_binarizer

module sgb_checker
    import sgb_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // a stalled result holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // binarized output is only ever one of the two marks
    a_binary: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:0] == EDGE_MARK) || (m_tdata[7:0] == FLAT_MARK))
        else $error("edge value is not binary");

    // frame end sits at an interior center pixel, never on the border
    a_last_interior: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> (m_tdata[18:8] != 11'd0) && (m_tdata[30:19] != 12'd0))
        else $error("frame end on border pixel");

    // padding bit stays clear
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[31])
        else $error("tdata padding set");

    // the input only stalls behind a result that waits on the receiver
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with no waiting result");

endmodule

bind gray_sobel_edge_binarizer sgb_checker u_sgb_checker (.*);

/* tb/tb_gray_sobel_edge_binarizer.sv */
// self-checking testbench for the gray_sobel_edge_binarizer stream block
// depends on sgb_pkg and the gray_sobel_edge_binarizer rtl; needs no files or arguments
// checks every output pixel against a cycle-free prediction of the sobel window
`timescale 1ns / 1ps

module tb_gray_sobel_edge_binarizer;

    import sgb_pkg::*;

    // one expected binarized pixel, fields as they travel on m_tdata / m_tlast
    typedef struct packed
    {
        logic [7:0]  level;
        logic [10:0] col;
        logic [11:0] row;
        logic        eof;
    } bin_pixel_t;

    // edge map predictor: mirrors the line stores, the window and the position
    // counters, and keeps the queue of binarized pixels still owed by the block
    class edge_map_predictor;
        logic [7:0]  upper_row [MAX_WIDTH_DEF];
        logic [7:0]  middle_row [MAX_WIDTH_DEF];
        logic [7:0]  win [6];    // 0..2 older column, 3..5 newer (top, mid, bottom)
        int unsigned col_pos;
        int unsigned row_pos;
        int unsigned width_reg;
        int unsigned height_reg;
        int unsigned thresh_reg;
        bin_pixel_t  expected_pixels [$];
        int          mismatches;
        int          checked;
        int          edges_seen;
        int          frame_ends;

        function new();
            foreach (upper_row[i])
            begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            foreach (win[i])
                win[i] = '0;
            col_pos    = 0;
            row_pos    = 0;
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            thresh_reg = THRESHOLD_RESET;
            mismatches = 0;
            checked    = 0;
            edges_seen = 0;
            frame_ends = 0;
        endfunction

        function int unsigned clamp_dim(int unsigned v, int unsigned hi);
            if (v < 3)
                return 3;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function int unsigned eff_width();
            return clamp_dim(width_reg, MAX_WIDTH_DEF);
        endfunction

        function int unsigned eff_height();
            return clamp_dim(height_reg, MAX_HEIGHT_DEF);
        endfunction

        function void set_reg(cfg_reg_t idx, logic [12:0] val);
            case (idx)
                REG_IMAGE_WIDTH:    width_reg  = val[11:0];
                REG_IMAGE_HEIGHT:   height_reg = val;
                REG_EDGE_THRESHOLD: thresh_reg = val[10:0];
                default:            ;
            endcase
        endfunction

        // one accepted pixel: advance position, update stores, maybe owe a result
        function void take_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit sof);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int unsigned rw;
            int unsigned shade;
            logic [7:0]  gray;
            logic [7:0]  top;
            logic [7:0]  mid;
            int          lc0, lc1, lc2, mc0, mc2, rc0, rc1, rc2, gx, gy, mag;
            bin_pixel_t  owed;

            w = eff_width();
            h = eff_height();
            if (sof)
            begin
                col_pos = 0;
                row_pos = 0;
            end
            // a shrunk width can leave the column past the row end
            if (col_pos >= w)
            begin
                col_pos = 0;
                row_pos++;
            end
            if (row_pos >= h)
                row_pos = 0;
            c  = col_pos;
            rw = row_pos;

            shade = (54 * int'(r) + 184 * int'(g) + 18 * int'(b)) >> 8;
            gray  = shade[7:0];

            top           = upper_row[c];
            mid           = middle_row[c];
            upper_row[c]  = mid;
            middle_row[c] = gray;
            if (rw == 1)
                top = gray;    // top border mirrored

            if (c >= 1 && rw >= 1)
            begin
                if (c == 1)
                begin
                    // left border mirrored: left column equals the current one
                    lc0 = int'(top);
                    lc1 = int'(mid);
                    lc2 = int'(gray);
                end
                else
                begin
                    lc0 = int'(win[0]);
                    lc1 = int'(win[1]);
                    lc2 = int'(win[2]);
                end
                mc0 = int'(win[3]);
                mc2 = int'(win[5]);
                rc0 = int'(top);
                rc1 = int'(mid);
                rc2 = int'(gray);
                gx  = -lc0 + rc0 - 2 * lc1 + 2 * rc1 - lc2 + rc2;
                gy  = -lc0 - 2 * mc0 - rc0 + lc2 + 2 * mc2 + rc2;
                mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
                owed.level = (mag >= int'(thresh_reg)) ? EDGE_MARK : FLAT_MARK;
                owed.col   = 11'(c - 1);
                owed.row   = 12'(rw - 1);
                owed.eof   = (c == w - 1) && (rw == h - 1);
                expected_pixels.push_back(owed);
            end

            win[0] = win[3];
            win[1] = win[4];
            win[2] = win[5];
            win[3] = top;
            win[4] = mid;
            win[5] = gray;

            col_pos = c + 1;
            if (col_pos >= w)
            begin
                col_pos = 0;
                row_pos = rw + 1;
                if (row_pos >= h)
                    row_pos = 0;
            end
        endfunction

        task flag_mismatch(string what);
            mismatches++;
            $display("%0t mismatch: %s", $time, what);
        endtask

        task check_pixel(logic [7:0] level, logic [10:0] col, logic [11:0] row, logic eof);
            bin_pixel_t want;
            if (expected_pixels.size() == 0)
            begin
                flag_mismatch($sformatf("result with nothing owed (col %0d row %0d)", col, row));
                return;
            end
            want = expected_pixels.pop_front();
            checked++;
            if (want.level == EDGE_MARK)
                edges_seen++;
            if (want.eof)
                frame_ends++;
            if (level !== want.level)
                flag_mismatch($sformatf("edge_value %0d, want %0d at col %0d row %0d",
                                        level, want.level, want.col, want.row));
            if (col !== want.col)
                flag_mismatch($sformatf("out_column %0d, want %0d", col, want.col));
            if (row !== want.row)
                flag_mismatch($sformatf("out_row %0d, want %0d", row, want.row));
            if (eof !== want.eof)
                flag_mismatch($sformatf("end_of_frame %0b, want %0b at col %0d row %0d",
                                        eof, want.eof, want.col, want.row));
        endtask
    endclass

    // clock, reset and the block's ports; every input starts at a known value
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;    // red[7:0], green[15:8], blue[23:16]
    logic [0:0]  s_tuser   = '0;    // start_of_frame[0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;           // edge_value[7:0], out_column[18:8], out_row[30:19], pad
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_reg_t    cfg_index = REG_IMAGE_WIDTH;
    logic [12:0] cfg_data  = '0;

    edge_map_predictor model;

    // pixels fed by the random part; the directed part adds 126 more
    localparam int RANDOM_ITEMS = 724;

    // idle rates in percent, set by the stimulus and read by both drivers
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    // bumped by the stimulus to ask the output side for one long hold-off
    int hold_grant  = 0;

    int pixels_sent = 0;
    int random_fed  = 0;
    int phases      = 0;

    gray_sobel_edge_binarizer u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    // offer one pixel, with random idle cycles ahead of it, and hold it until the
    // transaction completes; valid stays high so back-to-back pixels need no gap
    task automatic send_pixel(input logic [23:0] rgb, input bit sof);
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rgb;
        s_tuser  <= sof;
        do
            @(posedge clk);
        while (!s_tready);
        model.take_pixel(rgb[7:0], rgb[15:8], rgb[23:16], sof);
        pixels_sent++;
    endtask

    // write the geometry and threshold registers; the block must be idle
    task automatic program_regs(input logic [12:0] w, input logic [12:0] h,
                                input logic [12:0] thr, input bit poke_unused);
        cfg_reg_t    idx;
        logic [12:0] val;
        for (int i = 0; i < 4; i++)
        begin
            idx = cfg_reg_t'(i);
            if (idx == REG_UNUSED && !poke_unused)
                continue;
            case (idx)
                REG_IMAGE_WIDTH:    val = w;
                REG_IMAGE_HEIGHT:   val = h;
                REG_EDGE_THRESHOLD: val = thr;
                default:            val = 13'h1abc;
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            do
                @(posedge clk);
            while (!cfg_ready);
            model.set_reg(idx, val);
        end
        cfg_valid <= 1'b0;
    endtask

    // drop valid, wait for every owed result, then let the two pipeline stages
    // run dry since pixels in the last column and row produce nothing
    task automatic settle();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (model.expected_pixels.size() != 0 && waited < 4000)
        begin
            @(posedge clk);
            waited++;
        end
        if (model.expected_pixels.size() != 0)
        begin
            model.flag_mismatch($sformatf("%0d results never arrived",
                                          model.expected_pixels.size()));
            model.expected_pixels.delete();
        end
        repeat (8) @(posedge clk);
    endtask

    // pixel content: full random, hard black/white, or neutral gray levels
    function automatic logic [23:0] pick_color(int style);
        logic [7:0] v;
        case (style)
            0:
                return 24'($urandom);
            1:
                return $urandom_range(1) ? 24'hffffff : 24'h000000;
            default:
            begin
                v = 8'($urandom_range(255));
                return {v, v, v};
            end
        endcase
    endfunction

    // one random phase: maybe new registers, then whole frames with random
    // content, sometimes a partial frame and stray start markers as noise;
    // never more pixels than the budget allows
    task automatic random_phase(input int unsigned budget);
        int unsigned w_raw;
        int unsigned h_raw;
        int unsigned thr;
        int unsigned old_w;
        int unsigned area;
        int unsigned n;
        int unsigned pick;
        bit          grow;
        bit          frame_marks;
        bit          sof;
        int          style;

        old_w = model.eff_width();
        if (phases == 0 || $urandom_range(4) != 0)
        begin
            pick  = $urandom_range(99);
            w_raw = (pick < 80) ? $urandom_range(3, 9) :
                    (pick < 95) ? $urandom_range(10, 40) : $urandom_range(0, 2);
            h_raw = ($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
            pick  = $urandom_range(9);
            thr   = (pick == 0) ? 0 :
                    (pick == 1) ? 2040 :
                    (pick == 2) ? 2047 :
                    (pick == 3) ? $urandom_range(900, 1600) : $urandom_range(0, 900);
            program_regs(13'(w_raw), 13'(h_raw), 13'(thr), 1'b0);
        end
        // a wider row than before would read line store entries never written,
        // so a widened frame always restarts with a start marker
        grow        = model.eff_width() > old_w;
        area        = model.eff_width() * model.eff_height();
        n           = area * $urandom_range(1, 3);
        if ($urandom_range(3) == 0)
            n += $urandom_range(1, area - 1);
        if (n > budget)
            n = budget;
        frame_marks = ($urandom_range(3) != 0);
        style       = $urandom_range(2);
        for (int unsigned i = 0; i < n; i++)
        begin
            sof = (i == 0) ? (grow || frame_marks) : (frame_marks && (i % area == 0));
            if ($urandom_range(99) < 2)
                sof = 1'b1;    // stray restart in the middle of a frame
            send_pixel(pick_color(style), sof);
            random_fed++;
        end
        settle();
        phases++;
    endtask

    // output side: checks each completed transaction, stalls at random and
    // serves the long hold-off on request, counted here cycle by cycle
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                model.check_pixel(m_tdata[7:0], m_tdata[18:8], m_tdata[30:19], m_tlast);
            if (hold_seen != hold_grant)
            begin
                hold_seen = hold_grant;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // stimulus and verdict
    initial
    begin
        logic [23:0] palette [9];
        logic [23:0] ramp [9];
        bit          pressed;
        int          bound;

        palette = '{24'h000000, 24'hffffff, 24'h0000ff, 24'h00ff00, 24'hff0000,
                    24'hffffff, 24'h000000, 24'h808080, 24'h00ffff};
        ramp    = '{24'h000000, 24'h000000, 24'h000000,
                    24'h000000, 24'hffffff, 24'hffffff,
                    24'hffffff, 24'hffffff, 24'hffffff};
        pressed = 1'b0;
        bound   = 0;
        model   = new();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part runs with both sides idling: sender light, receiver heavy
        tx_idle_pct = 26;
        rx_idle_pct = 65;

        // smallest frame, pure colors, zero threshold marks every pixel as edge;
        // the spare register index is written once and must change nothing
        program_regs(13'd3, 13'd3, 13'd0, 1'b1);
        foreach (palette[i])
            send_pixel(palette[i], i == 0);
        settle();

        // width and height below range clamp to 3, threshold above any gradient
        program_regs(13'd2, 13'd0, 13'd2047, 1'b0);
        for (int i = 0; i < 9; i++)
            send_pixel((i % 2) ? 24'hffffff : 24'h000000, i == 0);
        settle();

        // sharp corner near the largest gradient; second frame has no start marker
        program_regs(13'd3, 13'd3, 13'd1020, 1'b0);
        for (int i = 0; i < 18; i++)
            send_pixel(ramp[i % 9], i == 0);
        settle();

        // widest rows: width and height above range clamp to the maximum, so a
        // stretch of the first row gives no result
        program_regs(13'd4095, 13'd8191, 13'd200, 1'b0);
        for (int i = 0; i < 60; i++)
            send_pixel(pick_color((i / 20) % 3), i == 0);
        settle();

        // shrink with no start marker: the column is past the new row end, so
        // the counters must wrap on their own
        program_regs(13'd5, 13'd3, 13'd254, 1'b0);
        for (int i = 0; i < 30; i++)
            send_pixel(pick_color(0), 1'b0);
        settle();

        // random part: three pacing regimes, one long output hold-off in the last
        while (random_fed < RANDOM_ITEMS)
        begin
            if (random_fed < RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 26;
                rx_idle_pct = 65;
                bound       = RANDOM_ITEMS / 3;
            end
            else if (random_fed < 2 * RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 65;
                rx_idle_pct = 26;
                bound       = 2 * RANDOM_ITEMS / 3;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                bound       = RANDOM_ITEMS;
                if (!pressed)
                begin
                    pressed = 1'b1;
                    hold_grant++;
                end
            end
            random_phase(bound - random_fed);
        end

        $display("fed %0d pixels, %0d of them in %0d random phases; checked %0d results",
                 pixels_sent, random_fed, phases, model.checked);
        $display("%0d edges, %0d frame ends; clamped sizes, thresholds 0..2047, both sides stalled",
                 model.edges_seen, model.frame_ends);
        if (model.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
